// ----- hw/rtl/kvspt_pkg.sv -----
// shared types, constants and codes of the slot position table
package kvspt_pkg;

	localparam int unsigned MaxSlotsDef = 1024;
	localparam int unsigned NsW         = 11;
	localparam int unsigned SuW         = 14;
	localparam int unsigned AddrW       = 48;
	localparam int unsigned PosW        = 32;
	localparam int unsigned SlotInW     = 10;
	localparam int unsigned CntW        = 32;
	localparam int unsigned CfgIdxW     = 2;
	localparam int unsigned AlignW      = 7;

	localparam logic [PosW-1:0] EmptyPos    = {PosW{1'b1}};
	localparam logic [NsW-1:0]  NumSlotsRst = 11'd1024;
	localparam logic [SuW-1:0]  SlotUnitsRst = 14'd2;

	typedef enum logic [1:0] {
		CMD_APPEND  = 2'd0,
		CMD_SCATTER = 2'd1,
		CMD_LOOKUP  = 2'd2,
		CMD_QUERY   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_MISS  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_NUM_SLOTS  = 2'd0,
		CFG_SLOT_UNITS = 2'd1,
		CFG_BASE_ADDR  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		cmd_t            cmd;
		logic [PosW-1:0] position;
		logic [NsW-1:0]  slot;
		logic            bad;
	} work_t;

endpackage

// ----- hw/rtl/kvspt_if.sv -----
// request and response channel interfaces
interface kvspt_req_if;
	import kvspt_pkg::*;

	logic               valid;
	logic               ready;
	cmd_t               cmd;
	logic [PosW-1:0]    position;
	logic [SlotInW-1:0] slot_index;

	modport source (output valid, output cmd, output position, output slot_index, input ready);
	modport sink (input valid, input cmd, input position, input slot_index, output ready);
endinterface

interface kvspt_rsp_if;
	import kvspt_pkg::*;

	logic               valid;
	logic               ready;
	status_t            status;
	logic [SlotInW-1:0] slot_out;
	logic [PosW-1:0]    stored_position;
	logic [AddrW-1:0]   key_addr;
	logic [AddrW-1:0]   value_addr;
	logic               evicted;
	logic [CntW-1:0]    appends_seen;
	logic [CntW-1:0]    evictions_seen;

	modport source (output valid, output status, output slot_out, output stored_position,
		output key_addr, output value_addr, output evicted, output appends_seen,
		output evictions_seen, input ready);
	modport sink (input valid, input status, input slot_out, input stored_position,
		input key_addr, input value_addr, input evicted, input appends_seen,
		input evictions_seen, output ready);
endinterface

// ----- hw/rtl/kvspt_mod.sv -----
// multi-cycle remainder unit, eight dividend bits per cycle
module kvspt_mod (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [kvspt_pkg::PosW-1:0] dividend,
	input  logic [kvspt_pkg::NsW-1:0]  divisor,
	output logic                     done,
	output logic [kvspt_pkg::NsW-1:0]  rem
);
	import kvspt_pkg::*;

	localparam int unsigned DigW  = 8;
	localparam int unsigned Steps = PosW / DigW;
	localparam int unsigned StW   = $clog2(Steps);

	logic [PosW-1:0] num_q;
	logic [NsW-1:0]  den_q;
	logic [NsW-1:0]  rem_q;
	logic [StW-1:0]  cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [NsW:0]    trial;
	logic [NsW-1:0]  part;
	logic [NsW-1:0]  rem_nxt;

	always_comb begin
		part = rem_q;
		trial = '0;
		for (int k = 0; k < DigW; k++) begin
			trial = {part, num_q[PosW-1-k]};
			if (trial >= {1'b0, den_q}) begin
				trial = trial - {1'b0, den_q};
			end
			part = trial[NsW-1:0];
		end
		rem_nxt = part;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == StW'(Steps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << DigW;
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ----- hw/rtl/kvspt_queue.sv -----
// two-entry work queue between front and back
module kvspt_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  kvspt_pkg::work_t  push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output kvspt_pkg::work_t  pop_data
);
	import kvspt_pkg::*;

	localparam int unsigned Depth = 2;
	localparam int unsigned PtrW  = $clog2(Depth);
	localparam int unsigned FillW = $clog2(Depth + 1);

	work_t            ent_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [FillW-1:0] fill_q;
	logic             push;
	logic             pop;

	assign push_ready = fill_q < FillW'(Depth);
	assign pop_valid  = fill_q != '0;
	assign pop_data   = ent_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: fill_q <= fill_q + 1'b1;
				2'b01: fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- hw/rtl/kvspt_front.sv -----
// front end: accepts commands, maps positions to slots, range checks
module kvspt_front #(
	parameter int unsigned MAX_SLOTS = kvspt_pkg::MaxSlotsDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	kvspt_req_if.sink                 req,
	input  logic [kvspt_pkg::NsW-1:0] num_slots,
	input  logic                      clr_done,
	output logic                      push_valid,
	input  logic                      push_ready,
	output kvspt_pkg::work_t          push_data
);
	import kvspt_pkg::*;

	localparam logic [NsW-1:0] NCap = (MAX_SLOTS >= (1 << NsW)) ? {NsW{1'b1}} : NsW'(MAX_SLOTS);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t         state_q;
	cmd_t            cmd_q;
	logic [PosW-1:0] pos_q;
	logic [NsW-1:0]  slot_q;
	logic            bad_q;
	logic [NsW-1:0]  n_eff;
	logic            accept;
	logic            mod_start;
	logic            mod_done;
	logic [NsW-1:0]  mod_rem;

	always_comb begin
		if (num_slots == '0) begin
			n_eff = NsW'(1);
		end else if (num_slots > NCap) begin
			n_eff = NCap;
		end else begin
			n_eff = num_slots;
		end
	end

	assign req.ready = (state_q == F_IDLE) && clr_done;
	assign accept    = req.valid && req.ready;
	assign mod_start = accept && (req.cmd inside {CMD_APPEND, CMD_LOOKUP});

	kvspt_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (req.position),
		.divisor  (n_eff),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= mod_start ? F_DIV : F_PUSH;
					end
				end
				F_DIV: begin
					if (mod_done) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= req.cmd;
			pos_q  <= req.position;
			slot_q <= NsW'(req.slot_index);
			bad_q  <= !mod_start && (NsW'(req.slot_index) >= n_eff);
		end else if (state_q == F_DIV && mod_done) begin
			slot_q <= mod_rem;
		end
	end

	assign push_valid = state_q == F_PUSH;
	assign push_data  = '{cmd: cmd_q, position: pos_q, slot: slot_q, bad: bad_q};

endmodule

// ----- hw/rtl/kvspt_back.sv -----
// back end: table read-modify-write, counters, slot addresses, result register
module kvspt_back #(
	parameter int unsigned MAX_SLOTS = kvspt_pkg::MaxSlotsDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	output logic                        q_ready,
	input  kvspt_pkg::work_t            q_data,
	input  logic [kvspt_pkg::SuW-1:0]   slot_units,
	input  logic [kvspt_pkg::AddrW-1:0] base_addr,
	output logic                        clr_done,
	kvspt_rsp_if.source                 rsp
);
	import kvspt_pkg::*;

	localparam int unsigned SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int unsigned IxW = (SW > NsW) ? SW : NsW;
	localparam int unsigned PrW = NsW + SuW;
	localparam int unsigned VsW = PrW + 2;

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_EXEC = 3'b010,
		B_ADDR = 3'b100
	} bstate_t;

	logic [PosW-1:0]    mem [MAX_SLOTS];
	bstate_t            state_q;
	work_t              wk_s1;
	logic [PosW-1:0]    rdata_q;
	logic               clr_busy_q;
	logic [SW-1:0]      clr_cnt_q;
	logic [CntW-1:0]    app_cnt_q;
	logic [CntW-1:0]    ev_cnt_q;
	logic [PosW-1:0]    stored_s2;
	status_t            status_s2;
	logic               ev_s2;
	logic [PrW-1:0]     prod_s2;

	logic               rsp_valid_q;
	status_t            status_q;
	logic [SlotInW-1:0] slot_out_q;
	logic [PosW-1:0]    stored_q;
	logic [AddrW-1:0]   key_q;
	logic [AddrW-1:0]   value_q;
	logic               evicted_q;
	logic [CntW-1:0]    apps_q;
	logic [CntW-1:0]    evs_q;

	logic               pop;
	logic [IxW-1:0]     q_slot_x;
	logic [IxW-1:0]     s1_slot_x;
	logic [SW-1:0]      rd_idx;
	logic [SW-1:0]      s1_idx;
	logic               is_wr;
	logic               ev;
	logic               mem_we;
	logic [SW-1:0]      mem_waddr;
	logic [PosW-1:0]    mem_wdata;
	logic [AddrW-1:0]   base_al;
	logic [VsW-1:0]     val_sum;
	logic [AddrW-1:0]   key_addr;
	logic [AddrW-1:0]   value_addr;
	logic               out_load;

	assign clr_done  = !clr_busy_q;
	assign q_ready   = (state_q == B_IDLE) && !clr_busy_q;
	assign pop       = q_valid && q_ready;
	assign q_slot_x  = IxW'(q_data.slot);
	assign s1_slot_x = IxW'(wk_s1.slot);
	assign rd_idx    = q_slot_x[SW-1:0];
	assign s1_idx    = s1_slot_x[SW-1:0];

	assign is_wr = (wk_s1.cmd == CMD_APPEND) || (wk_s1.cmd == CMD_SCATTER && !wk_s1.bad);
	assign ev    = is_wr && (rdata_q != EmptyPos) && (rdata_q != wk_s1.position);

	assign mem_we    = clr_busy_q || (state_q == B_EXEC && is_wr);
	assign mem_waddr = clr_busy_q ? clr_cnt_q : s1_idx;
	assign mem_wdata = clr_busy_q ? EmptyPos : wk_s1.position;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (pop) begin
			rdata_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == SW'(MAX_SLOTS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign base_al    = {base_addr[AddrW-1:AlignW], {AlignW{1'b0}}};
	assign val_sum    = {1'b0, prod_s2, 1'b0} + VsW'(slot_units);
	assign key_addr   = base_al + AddrW'({prod_s2, {AlignW{1'b0}}});
	assign value_addr = base_al + AddrW'({val_sum, {(AlignW - 1){1'b0}}});
	assign out_load   = (state_q == B_ADDR) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			app_cnt_q   <= '0;
			ev_cnt_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						state_q <= B_EXEC;
					end
				end
				B_EXEC: begin
					state_q <= B_ADDR;
					if (wk_s1.cmd == CMD_APPEND) begin
						app_cnt_q <= app_cnt_q + 1'b1;
					end
					if (ev) begin
						ev_cnt_q <= ev_cnt_q + 1'b1;
					end
				end
				B_ADDR: begin
					if (out_load) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			wk_s1 <= q_data;
		end
		if (state_q == B_EXEC) begin
			ev_s2   <= ev;
			prod_s2 <= {{SuW{1'b0}}, wk_s1.slot} * {{NsW{1'b0}}, slot_units};
			if (wk_s1.bad) begin
				stored_s2 <= EmptyPos;
				status_s2 <= ST_RANGE;
			end else begin
				stored_s2 <= is_wr ? wk_s1.position : rdata_q;
				status_s2 <= (wk_s1.cmd == CMD_LOOKUP && rdata_q != wk_s1.position) ?
					ST_MISS : ST_OK;
			end
		end
		if (out_load) begin
			status_q   <= status_s2;
			slot_out_q <= wk_s1.slot[SlotInW-1:0];
			stored_q   <= stored_s2;
			key_q      <= wk_s1.bad ? '0 : key_addr;
			value_q    <= wk_s1.bad ? '0 : value_addr;
			evicted_q  <= ev_s2;
			apps_q     <= app_cnt_q;
			evs_q      <= ev_cnt_q;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = status_q;
	assign rsp.slot_out        = slot_out_q;
	assign rsp.stored_position = stored_q;
	assign rsp.key_addr        = key_q;
	assign rsp.value_addr      = value_q;
	assign rsp.evicted         = evicted_q;
	assign rsp.appends_seen    = apps_q;
	assign rsp.evictions_seen  = evs_q;

`ifndef SYNTHESIS
	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !pop) else $error("work popped during table clear");
	a_evict_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EXEC && ev) |=> (ev_cnt_q == $past(ev_cnt_q) + 1'b1))
		else $error("eviction not counted");
	a_append_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EXEC && wk_s1.cmd == CMD_APPEND) |=>
		(app_cnt_q == $past(app_cnt_q) + 1'b1)) else $error("append not counted");
	a_range_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EXEC && wk_s1.bad) |-> !mem_we)
		else $error("table written on out of range slot");
`endif

endmodule

// ----- hw/rtl/kv_slot_position_table_core.sv -----
// top level of the slot position table: config registers, front, queue, back
// append and lookup pass the remainder unit before the queue; scatter and query go to the queue directly
// the front end takes a new command only once the previous one is pushed into the queue, and the
// back end takes the next queued command only once its result register is loaded
// after reset the table is cleared one slot per cycle, req.ready held low
module kv_slot_position_table_core #(
	parameter int unsigned MAX_SLOTS = kvspt_pkg::MaxSlotsDef
) (
	input  logic                            clk,
	input  logic                            arst_n,
	kvspt_req_if.sink                       req,
	kvspt_rsp_if.source                     rsp,
	input  logic                            cfg_we,
	input  logic [kvspt_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [kvspt_pkg::AddrW-1:0]     cfg_data
);
	import kvspt_pkg::*;

	logic [NsW-1:0]   num_slots_q;
	logic [SuW-1:0]   slot_units_q;
	logic [AddrW-1:0] base_addr_q;
	logic             clr_done;
	logic             push_valid;
	logic             push_ready;
	work_t            push_data;
	logic             pop_valid;
	logic             pop_ready;
	work_t            pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_slots_q  <= NumSlotsRst;
			slot_units_q <= SlotUnitsRst;
			base_addr_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUM_SLOTS:  num_slots_q  <= cfg_data[NsW-1:0];
				CFG_SLOT_UNITS: slot_units_q <= cfg_data[SuW-1:0];
				CFG_BASE_ADDR:  base_addr_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	kvspt_front #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.num_slots  (num_slots_q),
		.clr_done   (clr_done),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	kvspt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	kvspt_back #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (pop_valid),
		.q_ready    (pop_ready),
		.q_data     (pop_data),
		.slot_units (slot_units_q),
		.base_addr  (base_addr_q),
		.clr_done   (clr_done),
		.rsp        (rsp)
	);

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// testbench for the slot position table: directed and random commands checked against a built-in predictor
module tb_top;
	import kvspt_pkg::*;

	typedef struct packed {
		cmd_t               cmd;
		logic [PosW-1:0]    position;
		logic [SlotInW-1:0] slot_index;
	} slot_cmd_t;

	typedef struct {
		status_t            status;
		logic [SlotInW-1:0] slot_out;
		logic [PosW-1:0]    stored_position;
		logic [AddrW-1:0]   key_addr;
		logic [AddrW-1:0]   value_addr;
		logic               evicted;
		logic [CntW-1:0]    appends_seen;
		logic [CntW-1:0]    evictions_seen;
	} slot_result_t;

	localparam int unsigned IdleLimit = 5000;
	localparam int unsigned RandPerPhase = 50;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [AddrW-1:0]    cfg_data;

	kvspt_req_if req();
	kvspt_rsp_if rsp();

	kv_slot_position_table_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state
	logic [PosW-1:0]  slot_positions [MaxSlotsDef];
	logic [CntW-1:0]  append_total = '0;
	logic [CntW-1:0]  evict_total = '0;
	logic [NsW-1:0]   cfg_num_slots = NumSlotsRst;
	logic [SuW-1:0]   cfg_slot_units = SlotUnitsRst;
	logic [AddrW-1:0] cfg_base = '0;

	slot_cmd_t       cmds_to_send [$];
	slot_result_t    slot_results_due [$];
	logic [PosW-1:0] known_positions [$];

	bit          calm = 1'b0;
	int unsigned src_hold = 0;
	int unsigned sink_hold = 0;
	int unsigned idle_cycles = 0;
	int unsigned mismatches = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int unsigned slots_in_use();
		if (cfg_num_slots == 0) return 1;
		if (cfg_num_slots > MaxSlotsDef) return MaxSlotsDef;
		return cfg_num_slots;
	endfunction

	function automatic slot_result_t predict_slot_cmd(slot_cmd_t c);
		slot_result_t    e;
		int unsigned     n;
		int unsigned     slot;
		logic [PosW-1:0] prior;
		logic [AddrW-1:0] key;
		n = slots_in_use();
		e.status = ST_OK;
		e.evicted = 1'b0;
		e.stored_position = EmptyPos;
		e.key_addr = '0;
		e.value_addr = '0;
		if (c.cmd == CMD_APPEND || c.cmd == CMD_LOOKUP) slot = c.position % n;
		else slot = c.slot_index;
		if ((c.cmd == CMD_SCATTER || c.cmd == CMD_QUERY) && slot >= n) begin
			e.status = ST_RANGE;
		end else begin
			if (c.cmd == CMD_APPEND || c.cmd == CMD_SCATTER) begin
				prior = slot_positions[slot];
				if (prior != EmptyPos && prior != c.position) begin
					e.evicted = 1'b1;
					evict_total++;
				end
				slot_positions[slot] = c.position;
				if (c.cmd == CMD_APPEND) append_total++;
			end
			e.stored_position = slot_positions[slot];
			if (c.cmd == CMD_LOOKUP && slot_positions[slot] != c.position) e.status = ST_MISS;
			key = (cfg_base & ~48'h7F) + AddrW'(64'(slot) * 64'(cfg_slot_units) * 64'd128);
			e.key_addr = key;
			e.value_addr = key + AddrW'(64'(cfg_slot_units) * 64'd64);
		end
		e.slot_out = SlotInW'(slot);
		e.appends_seen = append_total;
		e.evictions_seen = evict_total;
		return e;
	endfunction

	function automatic slot_cmd_t mk(cmd_t c, logic [PosW-1:0] p, logic [SlotInW-1:0] s);
		slot_cmd_t r;
		r.cmd = c;
		r.position = p;
		r.slot_index = s;
		return r;
	endfunction

	// mostly reuse recent positions so lookups hit and appends collide
	function automatic slot_cmd_t random_cmd(int unsigned n);
		slot_cmd_t   r;
		int unsigned pick;
		r.cmd = cmd_t'($urandom_range(0, 3));
		pick = $urandom_range(0, 99);
		if (pick < 45 && known_positions.size() != 0)
			r.position = known_positions[$urandom_range(0, known_positions.size() - 1)];
		else if (pick < 65 && known_positions.size() != 0)
			r.position = known_positions[$urandom_range(0, known_positions.size() - 1)]
				+ n * $urandom_range(1, 4);
		else if (pick < 85)
			r.position = $urandom_range(0, 4 * n);
		else if (pick < 95)
			r.position = $urandom;
		else
			r.position = EmptyPos - $urandom_range(0, 1);
		if ($urandom_range(0, 9) < 7) r.slot_index = SlotInW'($urandom_range(0, n - 1));
		else r.slot_index = SlotInW'($urandom);
		if (r.cmd == CMD_APPEND || r.cmd == CMD_SCATTER) begin
			known_positions.push_back(r.position);
			if (known_positions.size() > 48) void'(known_positions.pop_front());
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic write_reg(cfg_idx_t idx, logic [AddrW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_NUM_SLOTS: cfg_num_slots = val[NsW-1:0];
			CFG_SLOT_UNITS: cfg_slot_units = val[SuW-1:0];
			default: cfg_base = val;
		endcase
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (cmds_to_send.size() != 0 || req.valid || slot_results_due.size() != 0);
	endtask

	// request driver
	always @(posedge clk) begin : drive_req
		slot_cmd_t nxt;
		if (arst_n && (!req.valid || req.ready)) begin
			if (src_hold > 0) begin
				src_hold--;
				req.valid <= 1'b0;
			end else if (cmds_to_send.size() != 0) begin
				nxt = cmds_to_send.pop_front();
				req.valid <= 1'b1;
				req.cmd <= nxt.cmd;
				req.position <= nxt.position;
				req.slot_index <= nxt.slot_index;
				src_hold = pick_gap();
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// response backpressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (sink_hold > 0) begin
				sink_hold--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				if ($urandom_range(0, 9) < 3) sink_hold = pick_gap();
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin : watch
		slot_cmd_t    seen;
		slot_result_t want;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				seen.cmd = req.cmd;
				seen.position = req.position;
				seen.slot_index = req.slot_index;
				slot_results_due.push_back(predict_slot_cmd(seen));
			end
			if (rsp.valid && rsp.ready) begin
				if (slot_results_due.size() == 0) begin
					$error("result beat with no command outstanding");
					mismatches++;
				end else begin
					want = slot_results_due.pop_front();
					check_field("status", 64'(want.status), 64'(rsp.status));
					check_field("slot_out", 64'(want.slot_out), 64'(rsp.slot_out));
					check_field("stored_position", 64'(want.stored_position),
						64'(rsp.stored_position));
					check_field("key_addr", 64'(want.key_addr), 64'(rsp.key_addr));
					check_field("value_addr", 64'(want.value_addr), 64'(rsp.value_addr));
					check_field("evicted", 64'(want.evicted), 64'(rsp.evicted));
					check_field("appends_seen", 64'(want.appends_seen), 64'(rsp.appends_seen));
					check_field("evictions_seen", 64'(want.evictions_seen),
						64'(rsp.evictions_seen));
				end
			end
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int unsigned n_eff;
		logic [NsW-1:0]   ns_set [8];
		logic [SuW-1:0]   su_set [8];
		logic [AddrW-1:0] base_set [8];

		for (int i = 0; i < MaxSlotsDef; i++) slot_positions[i] = EmptyPos;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.cmd = CMD_APPEND;
		req.position = '0;
		req.slot_index = '0;
		rsp.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_NUM_SLOTS;
		cfg_data = '0;

		// settings per phase: reset values and extremes mixed with random picks
		ns_set = '{NumSlotsRst, 11'd1, 11'd0, 11'd2047, 11'($urandom_range(2, 40)),
			11'd1024, 11'($urandom_range(1, 1024)), 11'd5};
		su_set = '{SlotUnitsRst, 14'd0, 14'd16383, 14'd1, 14'($urandom_range(2, 64)),
			14'd16383, 14'($urandom_range(0, 16383)), 14'd2};
		base_set = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FF80, 48'({$urandom, $urandom}),
			48'({$urandom, $urandom}), 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
			48'h80};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// table clear runs after reset
		do @(posedge clk);
		while (!req.ready);

		for (int p = 0; p < 8; p++) begin
			if (p > 0) begin
				write_reg(CFG_NUM_SLOTS, AddrW'(ns_set[p]));
				write_reg(CFG_SLOT_UNITS, AddrW'(su_set[p]));
				write_reg(CFG_BASE_ADDR, base_set[p]);
				@(posedge clk);
				cfg_we <= 1'b0;
			end
			calm = (p == 2 || p == 7);
			n_eff = slots_in_use();
			if (p == 0) begin
				cmds_to_send.push_back(mk(CMD_LOOKUP, 32'd0, 10'd0));
				cmds_to_send.push_back(mk(CMD_LOOKUP, EmptyPos, 10'd0));
				cmds_to_send.push_back(mk(CMD_QUERY, 32'd0, 10'd1023));
				cmds_to_send.push_back(mk(CMD_APPEND, 32'd0, 10'd0));
				cmds_to_send.push_back(mk(CMD_APPEND, 32'd1024, 10'd0));
				cmds_to_send.push_back(mk(CMD_APPEND, 32'd1024, 10'd0));
				cmds_to_send.push_back(mk(CMD_APPEND, EmptyPos, 10'd0));
				cmds_to_send.push_back(mk(CMD_APPEND, 32'hFFFF_FFFE, 10'd0));
				cmds_to_send.push_back(mk(CMD_SCATTER, 32'd5, 10'd1023));
				cmds_to_send.push_back(mk(CMD_SCATTER, EmptyPos, 10'd1023));
				cmds_to_send.push_back(mk(CMD_SCATTER, 32'hFFFF_FFFE, 10'd1022));
				cmds_to_send.push_back(mk(CMD_QUERY, 32'd0, 10'd1022));
				cmds_to_send.push_back(mk(CMD_LOOKUP, 32'd1024, 10'd0));
				cmds_to_send.push_back(mk(CMD_LOOKUP, 32'd0, 10'd0));
				cmds_to_send.push_back(mk(CMD_LOOKUP, EmptyPos, 10'd0));
				cmds_to_send.push_back(mk(CMD_SCATTER, 32'h5555_AAAA, 10'h2AA));
				cmds_to_send.push_back(mk(CMD_QUERY, 32'hAAAA_5555, 10'h155));
			end else if (p == 1) begin
				// single slot: in-range and out-of-range scatter and query, then a lookup and an append
				cmds_to_send.push_back(mk(CMD_SCATTER, 32'd7, 10'd0));
				cmds_to_send.push_back(mk(CMD_SCATTER, 32'd9, 10'd1));
				cmds_to_send.push_back(mk(CMD_QUERY, 32'd0, 10'd1023));
				cmds_to_send.push_back(mk(CMD_QUERY, 32'd0, 10'd0));
				cmds_to_send.push_back(mk(CMD_LOOKUP, 32'd7, 10'd0));
				cmds_to_send.push_back(mk(CMD_APPEND, 32'd12345, 10'd0));
			end
			for (int i = 0; i < RandPerPhase; i++) cmds_to_send.push_back(random_cmd(n_eff));
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && slot_results_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/kvspt_pkg.sv
hw/rtl/kvspt_if.sv
hw/rtl/kvspt_mod.sv
hw/rtl/kvspt_queue.sv
hw/rtl/kvspt_front.sv
hw/rtl/kvspt_back.sv
hw/rtl/kv_slot_position_table_core.sv
test/tb_top.sv
